// ===== hw/rtl/kwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int VAL_W      = 32;
    localparam int FROM_W     = 4;
    localparam int OUT_DATA_W = 40;

    // list counts selected by the sixteen_lists register
    localparam int LISTS_LO = 8;
    localparam int LISTS_HI = 16;

    // fill counter saturates at its top value
    localparam int          FILL_W   = 5;
    localparam logic [4:0]  FILL_MAX = 5'd31;

    // configuration port
    localparam int         APB_ADDR_W        = 3;
    localparam int         APB_DATA_W        = 32;
    localparam logic [0:0] REG_SIXTEEN_LISTS = 1'b0;   // register index, paddr[2]

endpackage

`default_nettype wire

// ===== hw/rtl/kwm_head_file.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwm_head_file #(
    parameter int NUM   = 16,
    parameter int VW    = 32,
    parameter int IDX_W = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    commit,
    input  wire logic                    wr_en,
    input  wire logic [IDX_W-1:0]        wr_idx,
    input  wire logic [VW-1:0]           wr_value,
    output logic      [NUM-1:0][VW-1:0]  view
);

    logic [NUM-1:0][VW-1:0] head_reg;
    logic [NUM-1:0][VW-1:0] head_next;

    // view shows the heads as they stand once the pending word is written
    always_comb begin
        for (int i = 0; i < NUM; i++) begin
            if (wr_en && (wr_idx == IDX_W'(i))) begin
                view[i] = wr_value;
            end else begin
                view[i] = head_reg[i];
            end
        end
    end

    always_comb begin
        head_next = head_reg;
        if (commit && wr_en) begin
            head_next = view;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else begin
            head_reg <= head_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kwm_max_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwm_max_tree
    import kwm_pkg::*;
#(
    parameter int NUM   = 16,
    parameter int VW    = 32,
    parameter int IDX_W = 4
) (
    input  wire logic [NUM-1:0][VW-1:0] heads,
    input  wire logic                   sixteen,
    output logic      [IDX_W-1:0]       best_idx,
    output logic      [VW-1:0]          best_val,
    output logic                        all_zero
);

    localparam int TREE_N = 1 << IDX_W;
    localparam int NODES  = 2 * TREE_N - 1;
    localparam int LEAF0  = TREE_N - 1;

    // heap layout: node j has children 2j+1 and 2j+2, leaves at the end
    logic [NODES-1:0][VW-1:0]    nd_val;
    logic [NODES-1:0][IDX_W-1:0] nd_idx;
    logic [NODES-1:0]            nd_ok;
    logic [TREE_N-1:0]           nz;

    genvar g;
    generate
        for (g = 0; g < TREE_N; g++) begin : g_leaf
            if (g < NUM) begin : g_real
                assign nd_val[LEAF0+g] = heads[g];
                assign nd_ok[LEAF0+g]  = (g < LISTS_LO) ? 1'b1 : sixteen;
            end else begin : g_pad
                assign nd_val[LEAF0+g] = '0;
                assign nd_ok[LEAF0+g]  = 1'b0;
            end
            assign nd_idx[LEAF0+g] = IDX_W'(g);
            assign nz[g] = nd_ok[LEAF0+g] && (|nd_val[LEAF0+g]);
        end

        for (g = 0; g < LEAF0; g++) begin : g_node
            logic take_r;
            // right side is the higher list index, so it wins only when strictly larger
            assign take_r = nd_ok[2*g+2] &&
                            (!nd_ok[2*g+1] ||
                             ($signed(nd_val[2*g+2]) > $signed(nd_val[2*g+1])));
            assign nd_val[g] = take_r ? nd_val[2*g+2] : nd_val[2*g+1];
            assign nd_idx[g] = take_r ? nd_idx[2*g+2] : nd_idx[2*g+1];
            assign nd_ok[g]  = nd_ok[2*g+1] | nd_ok[2*g+2];
        end
    endgenerate

    assign best_val = nd_val[0];
    assign best_idx = nd_idx[0];
    assign all_zero = ~(|nz);

endmodule

`default_nettype wire

// ===== hw/rtl/kway_max_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | ports               | payload
// ----------+-----------+---------------------+------------------------------------------
// s_        | in        | tvalid tready tdata | next_value[31:0]
// m_        | out       | tvalid tready tdata | merged_value[31:0], from_list[35:32]
//           |           | tuser               | done_res
// apb       | in        | psel penable ...    | sixteen_lists at address 0, bit 0
//
// one word per cycle sustained while a held result does not stall it; an accepted word waits in the input
// register, then the head update and the max tree load the result register that drives m_
// synchronous active-low reset clears the heads, starts the fill phase, 16 lists
// a held result stalls only words that produce a result; fill words pass on

module kway_max_merge
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] next_value

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] merged_value, [35:32] from_list
    output logic                       m_tuser,   // [0] done_res

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W   = $clog2(MAX_LISTS);
    localparam int HI_CNT  = (MAX_LISTS < LISTS_HI) ? MAX_LISTS : LISTS_HI;

    // configuration
    logic sixteen_reg, sixteen_next;
    logic cfg_wr;

    // input register
    logic                 in_vld_reg, in_vld_next;
    logic [IN_DATA_W-1:0] in_val_reg, in_val_next;

    // merge control
    logic [FILL_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic              merging_reg, merging_next;
    logic [IDX_W-1:0]  last_sel_reg, last_sel_next;

    // result register
    logic              m_vld_reg, m_vld_next;
    logic [VAL_W-1:0]  m_val_reg, m_val_next;
    logic [FROM_W-1:0] m_from_reg, m_from_next;
    logic              m_done_reg, m_done_next;

    logic [VALUE_WIDTH-1:0]                in_ext;
    logic [FILL_W-1:0]                     fill_inc;
    logic [FILL_W-1:0]                     list_cnt;
    logic                                  wr_en;
    logic [IDX_W-1:0]                      wr_idx;
    logic                                  eval_en;
    logic                                  can_go;
    logic                                  process;
    logic [MAX_LISTS-1:0][VALUE_WIDTH-1:0] view;
    logic [IDX_W-1:0]                      best_idx;
    logic [VALUE_WIDTH-1:0]                best_val;
    logic                                  all_zero;
    logic [VAL_W-1:0]                      best_out;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SIXTEEN_LISTS) ? {{(APB_DATA_W-1){1'b0}}, sixteen_reg}
                                                    : '0;

    always_comb begin
        sixteen_next = sixteen_reg;
        if (cfg_wr && (paddr[2] == REG_SIXTEEN_LISTS)) begin
            sixteen_next = pwdata[0];
        end
    end

    // word width conversion in and out of the head width
    generate
        if (VALUE_WIDTH > IN_DATA_W) begin : g_in_wide
            assign in_ext = {{(VALUE_WIDTH-IN_DATA_W){in_val_reg[IN_DATA_W-1]}}, in_val_reg};
        end else begin : g_in_narrow
            assign in_ext = in_val_reg[VALUE_WIDTH-1:0];
        end
        if (VALUE_WIDTH >= VAL_W) begin : g_out_wide
            assign best_out = best_val[VAL_W-1:0];
        end else begin : g_out_narrow
            assign best_out = {{(VAL_W-VALUE_WIDTH){1'b0}}, best_val};
        end
    endgenerate

    assign fill_inc = (fill_cnt_reg == FILL_MAX) ? fill_cnt_reg : fill_cnt_reg + 1'b1;
    assign list_cnt = sixteen_reg ? FILL_W'(HI_CNT) : FILL_W'(LISTS_LO);

    assign wr_en   = merging_reg || (fill_cnt_reg < FILL_W'(MAX_LISTS));
    assign wr_idx  = merging_reg ? last_sel_reg : fill_cnt_reg[IDX_W-1:0];
    assign eval_en = merging_reg || (fill_inc >= list_cnt);

    // a word that gives no result never waits on the output side
    assign can_go   = !eval_en || !m_vld_reg || m_tready;
    assign process  = in_vld_reg && can_go;
    assign s_tready = !in_vld_reg || can_go;

    kwm_head_file #(
        .NUM   (MAX_LISTS),
        .VW    (VALUE_WIDTH),
        .IDX_W (IDX_W)
    ) u_heads (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .commit   (process),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_value (in_ext),
        .view     (view)
    );

    kwm_max_tree #(
        .NUM   (MAX_LISTS),
        .VW    (VALUE_WIDTH),
        .IDX_W (IDX_W)
    ) u_tree (
        .heads    (view),
        .sixteen  (sixteen_reg),
        .best_idx (best_idx),
        .best_val (best_val),
        .all_zero (all_zero)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        in_val_next = in_val_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
            in_val_next = s_tdata;
        end else if (process) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        merging_next  = merging_reg;
        last_sel_next = last_sel_reg;
        m_vld_next    = m_tready ? 1'b0 : m_vld_reg;
        m_val_next    = m_val_reg;
        m_from_next   = m_from_reg;
        m_done_next   = m_done_reg;
        if (process) begin
            if (!merging_reg) begin
                fill_cnt_next = fill_inc;
            end
            if (eval_en) begin
                m_vld_next = 1'b1;
                if (all_zero) begin
                    // done: heads keep their values, next words refill from list 0
                    merging_next = 1'b0;
                    fill_cnt_next = '0;
                    m_val_next    = '0;
                    m_from_next   = '0;
                    m_done_next   = 1'b1;
                end else begin
                    merging_next  = 1'b1;
                    last_sel_next = best_idx;
                    m_val_next    = best_out;
                    m_from_next   = FROM_W'(best_idx);
                    m_done_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sixteen_reg  <= 1'b1;
            in_vld_reg   <= 1'b0;
            fill_cnt_reg <= '0;
            merging_reg  <= 1'b0;
            last_sel_reg <= '0;
            m_vld_reg    <= 1'b0;
        end else begin
            sixteen_reg  <= sixteen_next;
            in_vld_reg   <= in_vld_next;
            fill_cnt_reg <= fill_cnt_next;
            merging_reg  <= merging_next;
            last_sel_reg <= last_sel_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_val_reg <= in_val_next;
        m_val_reg  <= m_val_next;
        m_from_reg <= m_from_next;
        m_done_reg <= m_done_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W-VAL_W-FROM_W){1'b0}}, m_from_reg, m_val_reg};
    assign m_tuser  = m_done_reg;

endmodule

`default_nettype wire

// ===== test/kway_max_merge_tb.sv =====
`timescale 1ns / 1ps

module kway_max_merge_tb;
    import kwm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int WORD_TARGET = 1900;
    localparam int CALM_AFTER  = 1650;
    localparam int LIST_DEPTH  = 12;

    typedef struct packed {
        logic [15:0][VAL_W-1:0] heads;
        logic [FILL_W-1:0]      fill_cnt;
        logic                   merging;
        logic [FROM_W-1:0]      last_pick;
        logic                   sixteen;
    } merge_state_t;

    typedef struct packed {
        logic [VAL_W-1:0]  merged_value;
        logic [FROM_W-1:0] from_list;
        logic              done_res;
    } pick_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] next_value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] merged_value, [35:32] from_list
    logic                  m_tuser;         // [0] done_res
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    kway_max_merge dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    logic [VAL_W-1:0] feed_words [$];
    pick_t            awaited_picks [$];
    merge_state_t     merge_now;
    merge_state_t     merge_plan;
    bit               word_taken;
    int               gap_left;
    int               stall_left;
    int               gap_odds;
    int               stall_odds;
    int               err_count;
    int               idle_cycles;
    int               total_words;

    logic [VAL_W-1:0] list_words [16][LIST_DEPTH];
    int               list_len [16];
    int               list_pos [16];

    // one word into the merger: refill or fill a head, then once the fill is complete pick the largest head
    function automatic bit merge_advance(inout merge_state_t st, input logic [VAL_W-1:0] word,
                                         output pick_t pk);
        int lists;
        int best;
        int i;
        bit any_set;
        lists = st.sixteen ? LISTS_HI : LISTS_LO;
        pk = '0;
        if (st.merging) begin
            st.heads[st.last_pick] = word;
        end else begin
            if (st.fill_cnt < LISTS_HI)
                st.heads[st.fill_cnt[3:0]] = word;
            if (st.fill_cnt != FILL_MAX)
                st.fill_cnt = st.fill_cnt + 1'b1;
            if (st.fill_cnt < lists)
                return 1'b0;
        end
        best = 0;
        any_set = 1'b0;
        for (i = 0; i < lists; i++) begin
            if (st.heads[i] != '0)
                any_set = 1'b1;
            // ties keep the lower list
            if ($signed(st.heads[i]) > $signed(st.heads[best]))
                best = i;
        end
        if (!any_set) begin
            pk.done_res = 1'b1;
            st.merging = 1'b0;
            st.fill_cnt = '0;
        end else begin
            pk.merged_value = st.heads[best];
            pk.from_list = best[3:0];
            st.last_pick = best[3:0];
            st.merging = 1'b1;
        end
        return 1'b1;
    endfunction

    // true for a negative head in any list; if evaluated, zero heads then win forever
    function automatic bit has_negative_head(merge_state_t st);
        int i;
        for (i = 0; i < 16; i++)
            if (st.heads[i][VAL_W-1])
                return 1'b1;
        return 1'b0;
    endfunction

    // input side: accept, predict, track config writes, watchdog
    always @(posedge aclk) begin
        pick_t pk;
        bit got;
        if (!aresetn) begin
            merge_now = '0;
            merge_now.sixteen = 1'b1;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                idle_cycles = 0;
                got = merge_advance(merge_now, s_tdata[VAL_W-1:0], pk);
                if (got)
                    awaited_picks.push_back(pk);
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_SIXTEEN_LISTS) begin
                merge_now.sixteen = pwdata[0];
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready)
                idle_cycles = 0;
            if (idle_cycles >= QUIET_LIMIT) begin
                $display("kway_max_merge regression: fail");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (feed_words.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                gap_left = $urandom_range(0, 12);
                s_tvalid <= 1'b0;
            end else begin
                s_tdata <= feed_words.pop_front();
                s_tvalid <= 1'b1;
            end
        end
        word_taken = 1'b0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pick_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_picks.size() == 0) begin
                $error("result word with nothing expected: merged_value %0d from_list %0d done_res %0d",
                       $signed(m_tdata[VAL_W-1:0]), m_tdata[VAL_W +: FROM_W], m_tuser);
                err_count++;
            end else begin
                want = awaited_picks.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.merged_value) begin
                    $error("merged_value: expected %0d, actual %0d",
                           $signed(want.merged_value), $signed(m_tdata[VAL_W-1:0]));
                    err_count++;
                end
                if (m_tdata[VAL_W +: FROM_W] !== want.from_list) begin
                    $error("from_list: expected %0d, actual %0d",
                           want.from_list, m_tdata[VAL_W +: FROM_W]);
                    err_count++;
                end
                if (m_tuser !== want.done_res) begin
                    $error("done_res: expected %0d, actual %0d", want.done_res, m_tuser);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (feed_words.size() != 0 || s_tvalid || awaited_picks.size() != 0) begin
            @(negedge aclk);
            // look only once the driver has settled its outputs for this cycle
            #1;
        end
        // fill words give no result but may still be in the pipe
        repeat (4) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_sixteen(input logic on);
        logic [APB_DATA_W-1:0] data;
        data = $urandom();
        data[0] = on;
        reg_write({REG_SIXTEEN_LISTS, 2'b00}, data);
        merge_plan.sixteen = on;
    endtask

    // descending positive lists; the zero terminator comes from running off the end
    task automatic make_lists();
        int k;
        int j;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] span;
        logic [VAL_W-1:0] step;
        bit deep;
        deep = ($urandom_range(0, 5) == 0);
        for (k = 0; k < 16; k++) begin
            list_len[k] = $urandom_range(0, deep ? LIST_DEPTH - 1 : 4);
            list_pos[k] = 0;
            case ($urandom_range(0, 2))
                0: begin
                    v = $urandom_range(1, 24);
                    span = 3;
                end
                1: begin
                    v = $urandom() >> 1;
                    if (v == 0)
                        v = 1;
                    span = v >> 2;
                end
                default: begin
                    v = 32'h7fff_ffff;
                    span = 32'h07ff_ffff;
                end
            endcase
            for (j = 0; j < list_len[k]; j++) begin
                list_words[k][j] = v;
                step = $urandom_range(0, span);
                v = (v > step) ? v - step : 1;
            end
        end
    endtask

    task automatic pick_idling();
        if (total_words > CALM_AFTER) begin
            gap_odds = 0;
            stall_odds = 0;
        end else begin
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 3;
                default: gap_odds = 9;
            endcase
            case ($urandom_range(0, 2))
                0: stall_odds = 0;
                1: stall_odds = 3;
                default: stall_odds = 9;
            endcase
        end
    endtask

    // one merge run, sometimes cut short in the fill or merge phase
    task automatic run_merge();
        logic want16;
        int cap;
        int n;
        int idx;
        logic [VAL_W-1:0] word;
        pick_t pk;
        bit got;
        // negative heads in lists 8..15 stay harmless only with eight lists
        if (merge_plan.merging && has_negative_head(merge_plan))
            want16 = 1'b0;
        else
            want16 = $urandom_range(0, 1);
        if (want16 != merge_plan.sixteen || $urandom_range(0, 5) == 0)
            set_sixteen(want16);
        pick_idling();
        make_lists();
        cap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 2000;
        n = 0;
        while (n < cap) begin
            idx = merge_plan.merging ? merge_plan.last_pick : merge_plan.fill_cnt[3:0];
            if (list_pos[idx] < list_len[idx]) begin
                word = list_words[idx][list_pos[idx]];
                list_pos[idx]++;
            end else begin
                word = '0;
            end
            if ($urandom_range(0, 24) == 0) begin
                word = $urandom();
                if (idx < LISTS_LO)
                    word[VAL_W-1] = 1'b0;
            end
            feed_words.push_back(word);
            n++;
            total_words++;
            got = merge_advance(merge_plan, word, pk);
            if (got && pk.done_res)
                break;
            if (merge_plan.merging && has_negative_head(merge_plan) && $urandom_range(0, 3) == 0)
                break;
        end
        wait_idle();
        merge_plan = merge_now;
    endtask

    initial begin
        err_count = 0;
        total_words = 0;
        gap_left = 0;
        stall_left = 0;
        gap_odds = 4;
        stall_odds = 4;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // sixteen lists: extremes, a tie on the top value, negatives in the upper half
        feed_words.push_back(32'h7fff_ffff);
        feed_words.push_back(32'h7fff_ffff);
        feed_words.push_back(32'd1);
        repeat (5) feed_words.push_back(32'd0);
        feed_words.push_back(32'h8000_0000);
        feed_words.push_back(32'hffff_ffff);
        repeat (6) feed_words.push_back(32'd0);
        // refills; the last two leave zero heads winning over the negatives
        feed_words.push_back(32'd5);
        repeat (4) feed_words.push_back(32'd0);
        wait_idle();
        // drop to eight lists mid merge so the negatives fall out and the run ends
        reg_write({REG_SIXTEEN_LISTS, 2'b00}, '0);
        feed_words.push_back(32'd0);
        wait_idle();
        merge_plan = merge_now;

        while (total_words < WORD_TARGET)
            run_merge();

        repeat (8) @(negedge aclk);
        if (err_count == 0)
            $display("kway_max_merge regression: pass");
        else
            $display("kway_max_merge regression: fail");
        $finish;
    end

endmodule
